/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file of the core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is low.
`define TGCP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// Clocked check that also runs during reset.
`define TGCP_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

/* rtl/core/tgcp_pkg.sv */
// Package of the tile grid collision probe: sizes, codes, states and
// the structs passed between the core modules. No dependencies.
package tgcp_pkg;

    // store size and tile pitch
    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int TILE_SIZE = 32;

    localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int ROW_IW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_IW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);

    // field widths
    localparam int CMD_W      = 3;
    localparam int TILE_IW    = 6;
    localparam int COORD_W    = 13;
    localparam int SIZE_W     = 10;
    localparam int CFG_W      = 7;
    localparam int MARGIN_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int EDGE_OUT_W = 12;
    localparam int EDGE_MAX   = 4095;

    // edge in pixels before saturation
    localparam int EDGE_W = $clog2(MAX_DIM * TILE_SIZE + 1);

    // tile index by reciprocal multiply; exact for dividends below 2^14
    localparam int DIVD_W  = 14;
    localparam int DIV_SH  = 24;
    localparam int RECIP   = (2 ** DIV_SH + TILE_SIZE - 1) / TILE_SIZE;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = DIVD_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 3'd0,
        CMD_FLOOR = 3'd1,
        CMD_CEIL  = 3'd2,
        CMD_LEFT  = 3'd3,
        CMD_RIGHT = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_RD,
        ST_WR_WB,
        ST_DIV,
        ST_SETUP,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [DIM_W-1:0]    eff_rows;
        logic [DIM_W-1:0]    eff_cols;
        logic [MARGIN_W-1:0] margin;
    } cfg_t;

    typedef struct packed {
        logic [ROW_IW-1:0]   rd_addr;
        logic                wr_en;
        logic [ROW_IW-1:0]   wr_addr;
        logic [MAX_COLS-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic                     valid;
        logic [1:0]               tag;
        logic signed [DIVD_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic                     valid;
        logic [1:0]               tag;
        logic signed [DIVD_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic                  found;
        logic [EDGE_OUT_W-1:0] edge_pos;
    } res_t;

endpackage

/* rtl/core/tgcp_tile_mem.sv */
// Solid-tile store: one row of tile bits per entry, registered read.
// Depends on tgcp_pkg. Per-row valid bits make unwritten rows read clear.
module tgcp_tile_mem (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tgcp_pkg::mem_req_t            req,
    output logic [tgcp_pkg::MAX_COLS-1:0] rd_data
);
    import tgcp_pkg::*;

    logic [MAX_COLS-1:0] tile_ram [MAX_ROWS];
    logic [MAX_COLS-1:0] rd_data_reg;
    logic                rd_ok_reg;
    logic [MAX_ROWS-1:0] row_ok_reg;
    logic [MAX_ROWS-1:0] row_ok_next;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            tile_ram[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= tile_ram[req.rd_addr];
        rd_ok_reg   <= row_ok_reg[req.rd_addr];
    end

    always_comb begin
        row_ok_next = row_ok_reg;
        if (req.wr_en) begin
            row_ok_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_ok_reg <= '0;
        end else begin
            row_ok_reg <= row_ok_next;
        end
    end

    assign rd_data = rd_ok_reg ? rd_data_reg : '0;

endmodule

/* rtl/core/tgcp_div_unit.sv */
// Shared tile-index unit: signed pixel / TILE_SIZE, truncating toward zero.
// Depends on tgcp_pkg. Two-stage pipeline: magnitude, then reciprocal multiply.
module tgcp_div_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  tgcp_pkg::div_req_t req,
    output tgcp_pkg::div_rsp_t rsp
);
    import tgcp_pkg::*;

    logic              v1_reg, v1_next;
    logic [1:0]        tag1_reg;
    logic              neg1_reg;
    logic [DIVD_W-1:0] mag1_reg, mag1_next;
    logic              v2_reg, v2_next;
    logic [1:0]        tag2_reg;
    logic              neg2_reg;
    logic [PROD_W-1:0] prod2_reg, prod2_next;
    logic [DIVD_W-1:0] qmag;

    assign v1_next    = req.valid;
    assign mag1_next  = req.dividend[DIVD_W-1] ? DIVD_W'(-req.dividend)
                                               : DIVD_W'(req.dividend);
    assign v2_next    = v1_reg;
    assign prod2_next = PROD_W'(mag1_reg) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        tag1_reg  <= req.tag;
        neg1_reg  <= req.dividend[DIVD_W-1];
        mag1_reg  <= mag1_next;
        tag2_reg  <= tag1_reg;
        neg2_reg  <= neg1_reg;
        prod2_reg <= prod2_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    assign qmag      = DIVD_W'(prod2_reg >> DIV_SH);
    assign rsp.valid = v2_reg;
    assign rsp.tag   = tag2_reg;
    assign rsp.quot  = neg2_reg ? -$signed(qmag) : $signed(qmag);

endmodule

/* rtl/core/tgcp_seq.sv */
// Sequencer of the probe: tile writes, index computation on the shared
// unit, and the lane scans. Depends on tgcp_pkg, drives the tile store.
module tgcp_seq (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tgcp_pkg::cfg_t                       cfg,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [tgcp_pkg::CMD_W-1:0]           s_cmd,
    input  logic [tgcp_pkg::TILE_IW-1:0]         s_tile_row,
    input  logic [tgcp_pkg::TILE_IW-1:0]         s_tile_col,
    input  logic                                 s_solid_bit,
    input  logic signed [tgcp_pkg::COORD_W-1:0]  s_box_x,
    input  logic signed [tgcp_pkg::COORD_W-1:0]  s_box_y,
    input  logic [tgcp_pkg::SIZE_W-1:0]          s_box_w,
    input  logic [tgcp_pkg::SIZE_W-1:0]          s_box_h,
    output tgcp_pkg::mem_req_t                   mem_req,
    input  logic [tgcp_pkg::MAX_COLS-1:0]        mem_rdata,
    output tgcp_pkg::div_req_t                   div_req,
    input  tgcp_pkg::div_rsp_t                   div_rsp,
    output logic                                 res_valid,
    output tgcp_pkg::res_t                       res,
    input  logic                                 res_ready
);
    import tgcp_pkg::*;

    // slots of the index results
    localparam logic [1:0] Q_NEAR_C = 2'd0;
    localparam logic [1:0] Q_FAR_C  = 2'd1;
    localparam logic [1:0] Q_NEAR_R = 2'd2;
    localparam logic [1:0] Q_FAR_R  = 2'd3;

    state_t state_reg, state_next;

    logic [TILE_IW-1:0]         row_reg, row_next;
    logic [TILE_IW-1:0]         col_reg, col_next;
    logic                       bit_reg, bit_next;
    logic signed [COORD_W-1:0]  x_reg, x_next;
    logic signed [COORD_W-1:0]  y_reg, y_next;
    logic [SIZE_W-1:0]          w_reg, w_next;
    logic [SIZE_W-1:0]          h_reg, h_next;
    logic                       vert_reg, vert_next;
    logic                       pos_reg, pos_next;
    logic [1:0]                 cnt_reg, cnt_next;
    logic                       issued_reg, issued_next;
    logic signed [DIVD_W-1:0]   q_reg [4];
    logic signed [DIVD_W-1:0]   q_next [4];
    logic                       lane_sel_reg, lane_sel_next;
    logic [IDX_W-1:0]           lane_reg, lane_next;
    logic [IDX_W-1:0]           iss_idx_reg, iss_idx_next;
    logic                       iss_act_reg, iss_act_next;
    logic                       chk_v_reg, chk_v_next;
    logic [IDX_W-1:0]           chk_idx_reg, chk_idx_next;
    logic                       found_reg, found_next;
    logic [EDGE_W-1:0]          best_reg, best_next;

    logic signed [DIVD_W-1:0]   x_ext, y_ext, opnd;
    logic signed [DIVD_W-1:0]   lane_a, lane_b, lane_q;
    logic [DIM_W-1:0]           scan_lim, lane_lim;
    logic signed [DIVD_W-1:0]   lim_s, lim_m1, lane_lim_s;
    logic signed [DIVD_W-1:0]   start_base, start_raw, start_cl;
    logic                       lane_ok, start_ok, at_end;
    logic [IDX_W-1:0]           col_chk;
    logic                       hit_bit;
    logic [DIM_W-1:0]           edge_tiles;
    logic [EDGE_W-1:0]          edge_val;
    logic                       better;
    logic                       wr_ok;
    logic [MAX_COLS-1:0]        wr_row;

    // dividends: near and far pixel edges, far ones pulled in by the margin
    assign x_ext = DIVD_W'(x_reg);
    assign y_ext = DIVD_W'(y_reg);
    always_comb begin
        case (cnt_reg)
            Q_NEAR_C: opnd = x_ext;
            Q_FAR_C:  opnd = x_ext + DIVD_W'(w_reg) - DIVD_W'(cfg.margin);
            Q_NEAR_R: opnd = y_ext;
            Q_FAR_R:  opnd = y_ext + DIVD_W'(h_reg) - DIVD_W'(cfg.margin);
            default:  opnd = x_ext;
        endcase
    end

    // lane and start selection
    assign lane_a     = vert_reg ? q_reg[Q_NEAR_C] : q_reg[Q_NEAR_R];
    assign lane_b     = vert_reg ? q_reg[Q_FAR_C]  : q_reg[Q_FAR_R];
    assign lane_q     = lane_sel_reg ? lane_b : lane_a;
    assign scan_lim   = vert_reg ? cfg.eff_rows : cfg.eff_cols;
    assign lane_lim   = vert_reg ? cfg.eff_cols : cfg.eff_rows;
    assign lim_s      = DIVD_W'(scan_lim);
    assign lim_m1     = lim_s - DIVD_W'(1);
    assign lane_lim_s = DIVD_W'(lane_lim);
    assign start_base = vert_reg ? (pos_reg ? q_reg[Q_FAR_R] : q_reg[Q_NEAR_R])
                                 : (pos_reg ? q_reg[Q_FAR_C] : q_reg[Q_NEAR_C]);
    assign start_raw  = pos_reg ? start_base + DIVD_W'(1) : start_base - DIVD_W'(1);
    assign start_cl   = pos_reg ? ((start_raw < 0) ? '0 : start_raw)
                                : ((start_raw > lim_m1) ? lim_m1 : start_raw);
    assign lane_ok    = (lane_q >= 0) && (lane_q < lane_lim_s);
    assign start_ok   = (start_cl >= 0) && (start_cl < lim_s);

    // scan step and hit check
    assign at_end     = pos_reg ? (DIM_W'(iss_idx_reg) == scan_lim - DIM_W'(1))
                                : (iss_idx_reg == '0);
    assign col_chk    = vert_reg ? lane_reg : chk_idx_reg;
    assign hit_bit    = mem_rdata[COL_IW'(col_chk)];
    assign edge_tiles = pos_reg ? DIM_W'(chk_idx_reg) : DIM_W'(chk_idx_reg) + DIM_W'(1);
    assign edge_val   = EDGE_W'(edge_tiles) * EDGE_W'(TILE_SIZE);
    assign better     = !found_reg || (pos_reg ? (edge_val < best_reg)
                                               : (edge_val > best_reg));

    // writes beyond the store are dropped
    assign wr_ok = (int'(row_reg) < MAX_ROWS) && (int'(col_reg) < MAX_COLS);
    always_comb begin
        wr_row = mem_rdata;
        wr_row[COL_IW'(col_reg)] = bit_reg;
    end

    always_comb begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        bit_next      = bit_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        vert_next     = vert_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        issued_next   = issued_reg;
        q_next        = q_reg;
        lane_sel_next = lane_sel_reg;
        lane_next     = lane_reg;
        iss_idx_next  = iss_idx_reg;
        iss_act_next  = iss_act_reg;
        chk_v_next    = chk_v_reg;
        chk_idx_next  = chk_idx_reg;
        found_next    = found_reg;
        best_next     = best_reg;

        s_ready          = 1'b0;
        mem_req          = '0;
        div_req.valid    = 1'b0;
        div_req.tag      = cnt_reg;
        div_req.dividend = opnd;
        res_valid        = 1'b0;
        res.found        = found_reg;
        res.edge_pos     = (int'(best_reg) > EDGE_MAX) ? EDGE_OUT_W'(EDGE_MAX)
                                                       : EDGE_OUT_W'(best_reg);

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    row_next      = s_tile_row;
                    col_next      = s_tile_col;
                    bit_next      = s_solid_bit;
                    x_next        = s_box_x;
                    y_next        = s_box_y;
                    w_next        = s_box_w;
                    h_next        = s_box_h;
                    vert_next     = (s_cmd == CMD_FLOOR) || (s_cmd == CMD_CEIL);
                    pos_next      = (s_cmd == CMD_FLOOR) || (s_cmd == CMD_RIGHT);
                    cnt_next      = Q_NEAR_C;
                    issued_next   = 1'b0;
                    lane_sel_next = 1'b0;
                    found_next    = 1'b0;
                    best_next     = '0;
                    if (s_cmd == CMD_WRITE) begin
                        state_next = ST_WR_RD;
                    end else if (s_cmd inside {CMD_FLOOR, CMD_CEIL, CMD_LEFT, CMD_RIGHT}) begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_WR_RD: begin
                mem_req.rd_addr = ROW_IW'(row_reg);
                state_next      = ST_WR_WB;
            end
            ST_WR_WB: begin
                mem_req.wr_en   = wr_ok;
                mem_req.wr_addr = ROW_IW'(row_reg);
                mem_req.wr_data = wr_row;
                state_next      = ST_IDLE;
            end
            ST_DIV: begin
                if (!issued_reg) begin
                    div_req.valid = 1'b1;
                    cnt_next      = cnt_reg + 2'd1;
                    if (cnt_reg == Q_FAR_R) begin
                        issued_next = 1'b1;
                    end
                end
                if (div_rsp.valid) begin
                    q_next[div_rsp.tag] = div_rsp.quot;
                    if (div_rsp.tag == Q_FAR_R) begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                lane_next    = IDX_W'(lane_q);
                iss_idx_next = IDX_W'(start_cl);
                iss_act_next = lane_ok && start_ok;
                chk_v_next   = 1'b0;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                mem_req.rd_addr = vert_reg ? ROW_IW'(iss_idx_reg) : ROW_IW'(lane_reg);
                chk_v_next      = iss_act_reg;
                chk_idx_next    = iss_idx_reg;
                if (iss_act_reg) begin
                    if (at_end) begin
                        iss_act_next = 1'b0;
                    end else begin
                        iss_idx_next = pos_reg ? iss_idx_reg + IDX_W'(1)
                                               : iss_idx_reg - IDX_W'(1);
                    end
                end
                if ((chk_v_reg && hit_bit) || (!chk_v_reg && !iss_act_reg)) begin
                    if (chk_v_reg && better) begin
                        best_next = edge_val;
                    end
                    if (chk_v_reg) begin
                        found_next = 1'b1;
                    end
                    iss_act_next = 1'b0;
                    chk_v_next   = 1'b0;
                    if (!lane_sel_reg && (lane_b != lane_a)) begin
                        lane_sel_next = 1'b1;
                        state_next    = ST_SETUP;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        bit_reg      <= bit_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        vert_reg     <= vert_next;
        pos_reg      <= pos_next;
        cnt_reg      <= cnt_next;
        issued_reg   <= issued_next;
        q_reg        <= q_next;
        lane_sel_reg <= lane_sel_next;
        lane_reg     <= lane_next;
        iss_idx_reg  <= iss_idx_next;
        chk_idx_reg  <= chk_idx_next;
        found_reg    <= found_next;
        best_reg     <= best_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            iss_act_reg <= 1'b0;
            chk_v_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iss_act_reg <= iss_act_next;
            chk_v_reg   <= chk_v_next;
        end
    end

endmodule

/* rtl/core/tile_grid_collision_probe.sv */
// Tile grid collision probe, top level. Holds the map registers and the
// result register; depends on tgcp_pkg, tgcp_tile_mem, tgcp_div_unit, tgcp_seq.
//
// The block keeps a MAX_ROWS x MAX_COLS grid of solid-tile bits (all clear
// after reset) and takes one input word at a time. A write word (cmd 0) sets
// or clears one tile and gives no result. A query word (floor, ceiling,
// left, right) gives exactly one result word: found and the pixel position
// of the nearest solid tile edge in that direction, 0 when nothing is hit.
// The shared index unit works out the four tile indices one after the
// other; then the scan reads one lane, or two when the box spans two, at
// one tile per cycle from the tile store's single read port. Codes 5 to 7
// are taken and dropped. The input side is not ready while a word is in
// work; a finished result waits in its own output register, so the next
// word is taken while the result is still pending.
// The map size and edge margin registers are written through cfg_we /
// cfg_addr / cfg_wdata and must only change while the block is idle.
module tile_grid_collision_probe (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_we,
    input  logic [tgcp_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [tgcp_pkg::CFG_W-1:0]           cfg_wdata,
    // input words
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [tgcp_pkg::CMD_W-1:0]           s_cmd,
    input  logic [tgcp_pkg::TILE_IW-1:0]         s_tile_row,
    input  logic [tgcp_pkg::TILE_IW-1:0]         s_tile_col,
    input  logic                                 s_solid_bit,
    input  logic signed [tgcp_pkg::COORD_W-1:0]  s_box_x,
    input  logic signed [tgcp_pkg::COORD_W-1:0]  s_box_y,
    input  logic [tgcp_pkg::SIZE_W-1:0]          s_box_w,
    input  logic [tgcp_pkg::SIZE_W-1:0]          s_box_h,
    // result words
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_found,
    output logic [tgcp_pkg::EDGE_OUT_W-1:0]      m_edge_pos
);
    import tgcp_pkg::*;

    localparam int CMPW = CFG_W + DIM_W;

    // map registers
    logic [CFG_W-1:0]    rows_reg, rows_next;
    logic [CFG_W-1:0]    cols_reg, cols_next;
    logic [MARGIN_W-1:0] margin_reg, margin_next;

    // result register
    logic                  m_valid_reg, m_valid_next;
    logic                  m_found_reg, m_found_next;
    logic [EDGE_OUT_W-1:0] m_edge_reg, m_edge_next;

    cfg_t                cfg;
    mem_req_t            mem_req;
    logic [MAX_COLS-1:0] mem_rdata;
    div_req_t            div_req;
    div_rsp_t            div_rsp;
    logic                res_valid;
    logic                res_ready;
    res_t                res;

    always_comb begin
        rows_next   = rows_reg;
        cols_next   = cols_reg;
        margin_next = margin_reg;
        if (cfg_we) begin
            case (cfg_addr)
                CFG_ROWS:   rows_next   = cfg_wdata;
                CFG_COLS:   cols_next   = cfg_wdata;
                CFG_MARGIN: margin_next = cfg_wdata[MARGIN_W-1:0];
                default:    ;
            endcase
        end
    end

    // map size clips to the store size; zero leaves an empty map
    assign cfg.eff_rows = (CMPW'(rows_reg) > CMPW'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                              : DIM_W'(rows_reg);
    assign cfg.eff_cols = (CMPW'(cols_reg) > CMPW'(MAX_COLS)) ? DIM_W'(MAX_COLS)
                                                              : DIM_W'(cols_reg);
    assign cfg.margin   = margin_reg;

    // result register loads when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_edge_next  = m_edge_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_found_next = res.found;
            m_edge_next  = res.edge_pos;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        m_found_reg <= m_found_next;
        m_edge_reg  <= m_edge_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg    <= CFG_W'(64);
            cols_reg    <= CFG_W'(64);
            margin_reg  <= MARGIN_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            rows_reg    <= rows_next;
            cols_reg    <= cols_next;
            margin_reg  <= margin_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_found    = m_found_reg;
    assign m_edge_pos = m_edge_reg;

    tgcp_tile_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (mem_rdata)
    );

    tgcp_div_unit u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    tgcp_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_tile_row  (s_tile_row),
        .s_tile_col  (s_tile_col),
        .s_solid_bit (s_solid_bit),
        .s_box_x     (s_box_x),
        .s_box_y     (s_box_y),
        .s_box_w     (s_box_w),
        .s_box_h     (s_box_h),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .res_valid   (res_valid),
        .res         (res),
        .res_ready   (res_ready)
    );

endmodule

/* rtl/core/tgcp_checker.sv */
// Port-level checks of the probe, bound onto the top level.
// Depends on tgcp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tgcp_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [tgcp_pkg::CMD_W-1:0]        s_cmd,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic                              m_found,
    input logic [tgcp_pkg::EDGE_OUT_W-1:0]   m_edge_pos
);
    import tgcp_pkg::*;

    // stalled result word holds
    `TGCP_ASSERT(a_res_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_edge_pos))

    // a miss reports position zero
    `TGCP_ASSERT(a_miss_zero, aclk, aresetn, m_valid && !m_found |-> m_edge_pos == '0)

    // a write or query word keeps the input side busy next cycle
    `TGCP_ASSERT(a_busy_after_take, aclk, aresetn, s_valid && s_ready && (s_cmd == CMD_WRITE || s_cmd == CMD_FLOOR || s_cmd == CMD_CEIL || s_cmd == CMD_LEFT || s_cmd == CMD_RIGHT) |=> !s_ready)

    // reset empties the result register
    `TGCP_ASSERT_NR(a_rst_empty, aclk, !aresetn |=> !m_valid)

endmodule

bind tile_grid_collision_probe tgcp_checker u_tgcp_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for tile_grid_collision_probe: directed table, then random words.
// Depends on tgcp_pkg and the RTL of the block; the scoreboard predicts each query result not typed in the table.
`timescale 1ns / 100ps

module tb;
    import tgcp_pkg::*;

    // codes the block must take and drop without a result
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

    localparam int N_PHASES     = 7;
    localparam int PHASE_WORDS  = 250;
    localparam int QUIET_CYCLES = 200;    // settle time, longer than the longest query or write
    localparam int HOLD_CYCLES  = 1500;   // receiver hold-off, long enough to fill the block
    localparam int STALL_LIMIT  = 20000;  // cycles with no handshake before giving up

    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic [TILE_IW-1:0]        tile_row;
        logic [TILE_IW-1:0]        tile_col;
        logic                      solid_bit;
        logic signed [COORD_W-1:0] box_x;
        logic signed [COORD_W-1:0] box_y;
        logic [SIZE_W-1:0]         box_w;
        logic [SIZE_W-1:0]         box_h;
    } word_t;

    typedef struct {
        word_t wd;
        bit    typed;    // expected result written into the table
        res_t  want;
    } dir_row_t;

    logic                      aclk;
    logic                      aresetn     = 1'b0;
    logic                      cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_addr    = '0;
    logic [CFG_W-1:0]          cfg_wdata   = '0;
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    logic [CMD_W-1:0]          s_cmd       = '0;
    logic [TILE_IW-1:0]        s_tile_row  = '0;
    logic [TILE_IW-1:0]        s_tile_col  = '0;
    logic                      s_solid_bit = 1'b0;
    logic signed [COORD_W-1:0] s_box_x     = '0;
    logic signed [COORD_W-1:0] s_box_y     = '0;
    logic [SIZE_W-1:0]         s_box_w     = '0;
    logic [SIZE_W-1:0]         s_box_h     = '0;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    logic                      m_found;
    logic [EDGE_OUT_W-1:0]     m_edge_pos;

    tile_grid_collision_probe DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_tile_row  (s_tile_row),
        .s_tile_col  (s_tile_col),
        .s_solid_bit (s_solid_bit),
        .s_box_x     (s_box_x),
        .s_box_y     (s_box_y),
        .s_box_w     (s_box_w),
        .s_box_h     (s_box_h),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_found     (m_found),
        .m_edge_pos  (m_edge_pos)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Shadow of the block: tile grid plus the three map registers,
    // tracked as the words are accepted.
    // ---------------------------------------------------------------
    bit [MAX_COLS-1:0] tile_map [MAX_ROWS];
    int map_rows_raw = 64;
    int map_cols_raw = 64;
    int margin_px    = 1;

    res_t     pending_results [$];   // expected result words, oldest first
    dir_row_t dir_rows [$];

    int  n_errors   = 0;
    int  n_queries  = 0;
    int  n_writes   = 0;
    int  n_spare    = 0;
    int  n_checked  = 0;
    int  n_hits     = 0;
    int  idle_count = 0;
    bit  hold_req   = 1'b0;  // asks the receiver for one long hold-off
    bit  steady_src = 1'b0;  // sender offers back to back, no gaps
    res_t want_res;

    // map size saturates at the store size; zero means an empty map
    function automatic int rows_eff();
        return (map_rows_raw > MAX_ROWS) ? MAX_ROWS : map_rows_raw;
    endfunction

    function automatic int cols_eff();
        return (map_cols_raw > MAX_COLS) ? MAX_COLS : map_cols_raw;
    endfunction

    // anything outside the map in use reads as open space
    function automatic bit tile_solid(int r, int c);
        if (r < 0 || c < 0 || r >= rows_eff() || c >= cols_eff())
            return 1'b0;
        return tile_map[r][c];
    endfunction

    // walk one lane outward from start; index of the first solid tile or -1
    function automatic int scan_lane(bit vertical, int lane, int start, int step);
        int limit;
        int i;
        limit = vertical ? rows_eff() : cols_eff();
        if (step > 0) begin
            if (start < 0) start = 0;
        end else if (start > limit - 1) begin
            start = limit - 1;
        end
        for (i = start; i >= 0 && i < limit; i += step) begin
            if (vertical ? tile_solid(i, lane) : tile_solid(lane, i))
                return i;
        end
        return -1;
    endfunction

    // nearest solid edge for one query word
    function automatic res_t nearest_edge(word_t wd);
        int   x, y, w, h;
        int   near_c, far_c, near_r, far_r;
        int   lane_a, lane_b, start, step, lane, hit, edge_px, best, k;
        bit   vertical, want_min, found;
        res_t res;
        x = int'(wd.box_x);
        y = int'(wd.box_y);
        w = int'(wd.box_w);
        h = int'(wd.box_h);
        // SV integer division truncates toward zero, as the block does
        near_c = x / TILE_SIZE;
        far_c  = (x + w - margin_px) / TILE_SIZE;
        near_r = y / TILE_SIZE;
        far_r  = (y + h - margin_px) / TILE_SIZE;
        vertical = 1'b1;
        lane_a = near_c;
        lane_b = far_c;
        start = far_r + 1;
        step = 1;
        want_min = 1'b1;
        case (wd.cmd)
            CMD_CEIL: begin
                start = near_r - 1;
                step = -1;
                want_min = 1'b0;
            end
            CMD_LEFT: begin
                vertical = 1'b0;
                lane_a = near_r;
                lane_b = far_r;
                start = near_c - 1;
                step = -1;
                want_min = 1'b0;
            end
            CMD_RIGHT: begin
                vertical = 1'b0;
                lane_a = near_r;
                lane_b = far_r;
                start = far_c + 1;
            end
            default: ;
        endcase
        found = 1'b0;
        best = 0;
        for (k = 0; k < 2; k++) begin
            lane = k ? lane_b : lane_a;
            if (!(k == 1 && lane_b == lane_a)) begin
                hit = scan_lane(vertical, lane, start, step);
                if (hit >= 0) begin
                    // floor/right hit the near face of the tile, ceiling/left the far one
                    edge_px = (step > 0 ? hit : hit + 1) * TILE_SIZE;
                    if (!found || (want_min ? edge_px < best : edge_px > best))
                        best = edge_px;
                    found = 1'b1;
                end
            end
        end
        if (best > EDGE_MAX) best = EDGE_MAX;
        res.found = found;
        res.edge_pos = found ? best[EDGE_OUT_W-1:0] : '0;
        return res;
    endfunction

    // update the shadow for an accepted word and queue its result, if any
    function automatic void account_word(word_t wd, bit typed, res_t want);
        if (wd.cmd == CMD_WRITE) begin
            tile_map[wd.tile_row][wd.tile_col] = wd.solid_bit;
            n_writes++;
        end else if (wd.cmd == CMD_FLOOR || wd.cmd == CMD_CEIL ||
                     wd.cmd == CMD_LEFT || wd.cmd == CMD_RIGHT) begin
            pending_results.insert(pending_results.size(), typed ? want : nearest_edge(wd));
            n_queries++;
        end else begin
            n_spare++;
        end
    endfunction

    // unused fields of every word carry random bits
    function automatic word_t noise_word();
        word_t wd;
        wd.cmd       = CMD_W'($urandom);
        wd.tile_row  = TILE_IW'($urandom);
        wd.tile_col  = TILE_IW'($urandom);
        wd.solid_bit = 1'($urandom);
        wd.box_x     = COORD_W'($urandom);
        wd.box_y     = COORD_W'($urandom);
        wd.box_w     = SIZE_W'($urandom);
        wd.box_h     = SIZE_W'($urandom);
        return wd;
    endfunction

    function automatic void add_write(int row, int col, bit solid);
        dir_row_t dr;
        dr.wd = noise_word();
        dr.wd.cmd = CMD_WRITE;
        dr.wd.tile_row = TILE_IW'(row);
        dr.wd.tile_col = TILE_IW'(col);
        dr.wd.solid_bit = solid;
        dr.typed = 1'b0;
        dr.want = '0;
        dir_rows.insert(dir_rows.size(), dr);
    endfunction

    function automatic void add_query(logic [CMD_W-1:0] cmd, int x, int y, int w, int h,
                                      bit typed, bit found, int edge_px);
        dir_row_t dr;
        dr.wd = noise_word();
        dr.wd.cmd = cmd;
        dr.wd.box_x = COORD_W'(x);
        dr.wd.box_y = COORD_W'(y);
        dr.wd.box_w = SIZE_W'(w);
        dr.wd.box_h = SIZE_W'(h);
        dr.typed = typed;
        dr.want.found = found;
        dr.want.edge_pos = EDGE_OUT_W'(edge_px);
        dir_rows.insert(dir_rows.size(), dr);
    endfunction

    // tile writes and queries mostly over the map in use, some with full random fields; also spare codes
    function automatic word_t random_word();
        word_t wd;
        int    r;
        wd = noise_word();
        r = $urandom_range(0, 99);
        if (r < 40) begin
            wd.cmd = CMD_WRITE;
            if (rows_eff() > 0 && $urandom_range(0, 4) != 0)
                wd.tile_row = TILE_IW'($urandom_range(0, rows_eff() - 1));
            if (cols_eff() > 0 && $urandom_range(0, 4) != 0)
                wd.tile_col = TILE_IW'($urandom_range(0, cols_eff() - 1));
        end else if (r < 95) begin
            wd.cmd = CMD_W'(CMD_FLOOR + $urandom_range(0, 3));
            if ($urandom_range(0, 9) != 0) begin
                wd.box_x = COORD_W'($urandom_range(0, cols_eff() * TILE_SIZE + 63) - 32);
                wd.box_y = COORD_W'($urandom_range(0, rows_eff() * TILE_SIZE + 63) - 32);
                wd.box_w = SIZE_W'($urandom_range(0, 95));
                wd.box_h = SIZE_W'($urandom_range(0, 95));
            end
        end else begin
            wd.cmd = CMD_W'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
        end
        return wd;
    endfunction

    // sender idle gap: mostly none or short, now and then long
    function automatic int sender_gap();
        int r;
        if (steady_src) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // offer one word, hold it until taken, then book it
    task automatic send_word(input word_t wd, input int gap, input bit typed, input res_t want);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= wd.cmd;
        s_tile_row  <= wd.tile_row;
        s_tile_col  <= wd.tile_col;
        s_solid_bit <= wd.solid_bit;
        s_box_x     <= wd.box_x;
        s_box_y     <= wd.box_y;
        s_box_w     <= wd.box_w;
        s_box_h     <= wd.box_h;
        do @(posedge aclk); while (!s_ready);
        account_word(wd, typed, want);
    endtask

    // stop offering and wait for every expected result; quiet adds settle time
    // so that a trailing tile write has finished before the map registers change
    task automatic drain(input bit quiet);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        if (quiet) repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic program_map(input int rows_v, input int cols_v, input int margin_v);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_ROWS;
        cfg_wdata <= CFG_W'(rows_v);
        @(posedge aclk);
        cfg_addr  <= CFG_COLS;
        cfg_wdata <= CFG_W'(cols_v);
        @(posedge aclk);
        cfg_addr  <= CFG_MARGIN;
        cfg_wdata <= CFG_W'(margin_v);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        map_rows_raw = rows_v;
        map_cols_raw = cols_v;
        margin_px    = margin_v;
    endtask

    // ---------------------------------------------------------------
    // Receiver: random ready pattern with long open stretches, plus one
    // long hold-off on request while the sender keeps offering words.
    // ---------------------------------------------------------------
    initial begin
        int run;
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 400)
                                                  : $urandom_range(1, 30);
                repeat (run) @(posedge aclk);
                gap = $urandom_range(0, 99);
                gap = (gap < 50) ? 0 : (gap < 90) ? $urandom_range(1, 4)
                                                  : $urandom_range(15, 80);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // result check: every accepted result word against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: found %0d edge_pos %0d",
                       m_found, m_edge_pos);
                n_errors++;
            end else begin
                want_res = pending_results.pop_front();
                n_checked++;
                if (want_res.found) n_hits++;
                if (m_found !== want_res.found) begin
                    $error("found: expected %0d, got %0d", want_res.found, m_found);
                    n_errors++;
                end
                if (m_edge_pos !== want_res.edge_pos) begin
                    $error("edge_pos: expected %0d, got %0d", want_res.edge_pos, m_edge_pos);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_count = 0;
        end else begin
            idle_count++;
            if (idle_count >= STALL_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence: reset, directed table at reset settings, then one
    // random phase per map setting.
    // ---------------------------------------------------------------
    initial begin
        int ph;
        int i;
        int rows_v;
        int cols_v;
        int margin_v;
        int fixed_rows [5];
        int fixed_cols [5];
        int fixed_margin [5];

        // extremes first, including the empty map and sizes past the store
        fixed_rows   = '{64, 1, 0, 127, 40};
        fixed_cols   = '{64, 1, 33, 100, 64};
        fixed_margin = '{0, 31, 12, 31, 1};

        // Directed words, reset settings: 64 x 64 map, margin 1.
        //        cmd        x      y      w     h     typed found edge
        add_query(CMD_FLOOR, 0,     0,     32,   32,   1,    0,    0);    // empty map
        add_write(10, 0, 1);
        add_query(CMD_FLOOR, 0,     0,     32,   32,   1,    1,    320);
        add_query(CMD_CEIL,  0,     640,   32,   32,   1,    1,    352);
        add_write(5, 63, 1);
        add_query(CMD_RIGHT, 0,     160,   32,   32,   1,    1,    2016);
        // far right box, start clipped to the last column: largest edge value
        add_query(CMD_LEFT,  4095,  160,   0,    0,    1,    1,    2048);
        add_write(63, 63, 1);
        // extreme box: near lane in map, far lane past the right border
        add_query(CMD_FLOOR, 2016,  -4096, 1023, 1023, 0,    0,    0);
        // both lanes left of the map
        add_query(CMD_CEIL,  -4096, 4095,  0,    0,    1,    0,    0);
        // negative left edge truncates to column 0, far lane is column -1
        add_query(CMD_FLOOR, -31,   0,     0,    32,   0,    0,    0);
        add_query(CMD_LEFT,  -31,   0,     10,   10,   0,    0,    0);
        add_query(CMD_SPARE_A, 0,   0,     32,   32,   0,    0,    0);
        add_query(CMD_SPARE_B, 0,   0,     32,   32,   0,    0,    0);
        add_query(CMD_SPARE_C, 0,   0,     32,   32,   0,    0,    0);
        add_write(10, 0, 0);
        add_query(CMD_FLOOR, 0,     0,     32,   32,   1,    0,    0);    // tile cleared
        add_query(CMD_RIGHT, 4095,  4095,  1023, 1023, 0,    0,    0);
        add_write(0, 0, 1);
        add_query(CMD_CEIL,  0,     32,    32,   0,    1,    1,    32);
        // two column lanes, the far one finds the tile
        add_query(CMD_FLOOR, 1984,  0,     64,   32,   0,    0,    0);
        add_query(CMD_LEFT,  2047,  2016,  1023, 0,    0,    0,    0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[d])
            send_word(dir_rows[d].wd, sender_gap(), dir_rows[d].typed, dir_rows[d].want);

        for (ph = 0; ph < N_PHASES; ph++) begin
            drain(1'b1);
            if (ph < 5) begin
                rows_v   = fixed_rows[ph];
                cols_v   = fixed_cols[ph];
                margin_v = fixed_margin[ph];
            end else begin
                rows_v   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(1, 64);
                cols_v   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(1, 64);
                margin_v = $urandom_range(0, 31);
            end
            program_map(rows_v, cols_v, margin_v);
            // large map: long hold-off on the result side fills the block
            if (ph == 3) hold_req = 1'b1;
            steady_src = (ph == 5);
            for (i = 0; i < PHASE_WORDS; i++) begin
                // mid-phase pause until the block has caught up
                if (ph == 4 && i == PHASE_WORDS / 2) drain(1'b0);
                send_word(random_word(), sender_gap(), 1'b0, '0);
            end
        end
        drain(1'b1);

        $display("Run covered %0d words: %0d queries, %0d tile writes, %0d spare codes,",
                 n_queries + n_writes + n_spare, n_queries, n_writes, n_spare);
        $display("%0d map settings; %0d result words compared, %0d with a solid edge found, %0d mismatches.",
                 N_PHASES + 1, n_checked, n_hits, n_errors);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/tgcp_pkg.sv
rtl/core/tgcp_tile_mem.sv
rtl/core/tgcp_div_unit.sv
rtl/core/tgcp_seq.sv
rtl/core/tile_grid_collision_probe.sv
rtl/core/tgcp_checker.sv
tb/tb.sv
